[rtl/uhcdp_pkg.sv]
// Shared constants, status codes and the hand-off record of the descriptor parser.
package uhcdp_pkg;

  // Byte positions and sub-descriptor starts.
  localparam logic [16:0] PosMax        = 17'h1FFFF;
  localparam logic [16:0] FirstSubStart = 17'd9;
  localparam int unsigned WinDepth      = 8;
  localparam int unsigned TailBytes     = 5;

  // Descriptor codes.
  localparam logic [7:0] ConfigType    = 8'h02;
  localparam logic [7:0] KindInterface = 8'h04;
  localparam logic [7:0] KindEndpoint  = 8'h05;
  localparam logic [7:0] HubClass      = 8'h09;
  localparam logic [1:0] InterruptAttr = 2'b11;
  localparam logic [15:0] DefaultMps   = 16'd2;

  typedef enum logic [1:0] {
    StatusHubFound   = 2'd0,
    StatusNotConfig  = 2'd1,
    StatusNoHub      = 2'd2,
    StatusZeroLength = 2'd3
  } status_e;

  // State captured on the last byte, handed to the finishing stage.
  typedef struct packed {
    logic [TailBytes-1:0][7:0] bytes;      // bytes at positions pos-4 .. pos
    logic [16:0]               pos;
    logic [15:0]               total_len;
    logic [16:0]               next_start;
    logic                      pending;    // a sub-descriptor still starts at or before pos
    logic                      header_ok;
    logic                      zero_seen;
    logic [7:0]                intf_class;
    logic [7:0]                ep_addr;
    logic [15:0]               ep_mps;
  } tail_snap_t;

endpackage

[rtl/usb_hub_config_descriptor_parser.sv]
// Top level of the configuration descriptor parser.
// Takes one descriptor byte per cycle while in_ready_o is high; input stalls while a snapshot waits.
// The byte marked last is captured into the walk stage's snapshot register, and the finishing stage,
// which runs up to five pending visits, registers the result from that snapshot.
// Reset clears the walk state and both valid flags; the next descriptor starts at offset 0,
// as it does after every last byte.
module usb_hub_config_descriptor_parser import uhcdp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [4:0]  endpoint_id_o,
  output logic [15:0] max_packet_o
);

  logic       snap_valid;
  tail_snap_t snap;
  logic       snap_take;

  // Byte walk and snapshot.
  uhcdp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .snap_valid_o (snap_valid),
    .snap_o       (snap),
    .snap_take_i  (snap_take)
  );

  // Final visits and result register.
  uhcdp_tail u_tail (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .snap_valid_i  (snap_valid),
    .snap_i        (snap),
    .snap_take_o   (snap_take),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .endpoint_id_o (endpoint_id_o),
    .max_packet_o  (max_packet_o)
  );

endmodule

[rtl/uhcdp_core.sv]
// Byte-by-byte front end: header capture, sub-descriptor walk and last-byte snapshot.
module uhcdp_core import uhcdp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       snap_valid_o,
  output tail_snap_t snap_o,
  input  logic       snap_take_i
);

  logic [16:0] pos_q;
  logic [15:0] total_q, total_d;
  logic [16:0] next_q, next_d;
  logic        hdr_ok_q, hdr_ok_d;
  logic        done_q, done_d;
  logic        zero_q, zero_d;
  logic [7:0]  cls_q, cls_d;
  logic [7:0]  addr_q, addr_d;
  logic [15:0] mps_q, mps_d;
  logic [7:0]  win_q [WinDepth];
  logic [7:0]  win_d [WinDepth];
  logic [7:0]  vb [6];
  logic        snap_valid_q;
  tail_snap_t  snap_q, snap_d;
  logic        accept;
  logic        visit_now;
  logic        past_end;

  assign in_ready_o   = !snap_valid_q || snap_take_i;
  assign accept       = in_valid_i && in_ready_o;
  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

  // Window update, header capture and the visit of a sub-descriptor whose byte 5 arrives now.
  always_comb begin
    win_d = win_q;
    win_d[pos_q[2:0]] = data_byte_i;

    hdr_ok_d = hdr_ok_q;
    total_d  = total_q;
    if (pos_q == 17'd1) begin
      hdr_ok_d = (data_byte_i == ConfigType);
    end else if (pos_q == 17'd2) begin
      total_d = {total_q[15:8], data_byte_i};
    end else if (pos_q == 17'd3) begin
      total_d = {data_byte_i, total_q[7:0]};
    end

    // Bytes 0..5 of the sub-descriptor that starts five bytes back.
    for (int k = 0; k < 6; k++) begin
      vb[k] = win_d[pos_q[2:0] + 3'(k + 3)];
    end

    visit_now = !done_q && (({1'b0, next_q} + 18'd5) == {1'b0, pos_q});
    past_end  = {1'b0, pos_q} >= ({2'b00, total_q} + 18'd3);

    next_d = next_q;
    done_d = done_q;
    zero_d = zero_q;
    cls_d  = cls_q;
    addr_d = addr_q;
    mps_d  = mps_q;
    if (visit_now) begin
      if (past_end) begin
        done_d = 1'b1;
      end else begin
        if (vb[1] == KindInterface) begin
          cls_d = vb[5];
        end else if (vb[1] == KindEndpoint && vb[3][1:0] == InterruptAttr) begin
          addr_d = vb[2];
          mps_d  = {vb[5], vb[4]};
        end
        if (vb[0] == 8'd0) begin
          zero_d = 1'b1;
          done_d = 1'b1;
        end else begin
          next_d = next_q + 17'(vb[0]);
        end
      end
    end

    // Snapshot for the finishing stage.
    for (int j = 0; j < TailBytes; j++) begin
      snap_d.bytes[j] = win_d[pos_q[2:0] + 3'(j + 4)];
    end
    snap_d.pos         = pos_q;
    snap_d.total_len   = total_d;
    snap_d.next_start  = next_d;
    snap_d.pending     = !done_d && (next_d <= pos_q);
    snap_d.header_ok   = hdr_ok_d;
    snap_d.zero_seen   = zero_d;
    snap_d.intf_class  = cls_d;
    snap_d.ep_addr     = addr_d;
    snap_d.ep_mps      = mps_d;
  end

  // Walk state; a last-byte transfer returns it to the reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      total_q  <= '0;
      next_q   <= FirstSubStart;
      hdr_ok_q <= 1'b0;
      done_q   <= 1'b0;
      zero_q   <= 1'b0;
      cls_q    <= '0;
      addr_q   <= '0;
      mps_q    <= '0;
    end else if (accept) begin
      if (last_byte_i) begin
        pos_q    <= '0;
        total_q  <= '0;
        next_q   <= FirstSubStart;
        hdr_ok_q <= 1'b0;
        done_q   <= 1'b0;
        zero_q   <= 1'b0;
        cls_q    <= '0;
        addr_q   <= '0;
        mps_q    <= '0;
      end else begin
        if (pos_q != PosMax) begin
          pos_q <= pos_q + 17'd1;
        end
        total_q  <= total_d;
        next_q   <= next_d;
        hdr_ok_q <= hdr_ok_d;
        done_q   <= done_d;
        zero_q   <= zero_d;
        cls_q    <= cls_d;
        addr_q   <= addr_d;
        mps_q    <= mps_d;
      end
    end
  end

  // Snapshot slot occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (accept && last_byte_i) begin
      snap_valid_q <= 1'b1;
    end else if (snap_take_i) begin
      snap_valid_q <= 1'b0;
    end
  end

  // Byte window and snapshot payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
    if (accept && last_byte_i) begin
      snap_q <= snap_d;
    end
  end

endmodule

[rtl/uhcdp_tail.sv]
// Finishing stage: walks the sub-descriptors left at the last byte and registers the result.
module uhcdp_tail import uhcdp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        snap_valid_i,
  input  tail_snap_t  snap_i,
  output logic        snap_take_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [4:0]  endpoint_id_o,
  output logic [15:0] max_packet_o
);

  logic [TailBytes-1:0] past_end;
  logic [7:0]  tb [16];
  logic        act;
  logic [3:0]  off;
  logic [7:0]  len;
  logic [7:0]  kind;
  logic        zero;
  logic [7:0]  cls;
  logic [7:0]  addr;
  logic [15:0] mps;
  status_e     status_d;
  logic [4:0]  id_d;
  logic [15:0] mps_d;
  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [4:0]  id_q;
  logic [15:0] mps_q;

  assign snap_take_o   = snap_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign endpoint_id_o = id_q;
  assign max_packet_o  = mps_q;

  // A start at offset o (position pos-4+o) ends the walk when it lies at total-2 or beyond.
  always_comb begin
    for (int o = 0; o < TailBytes; o++) begin
      past_end[o] = ({1'b0, snap_i.pos} + 18'(o)) >= ({2'b00, snap_i.total_len} + 18'd2);
    end
    // Bytes past the last one read as zero.
    for (int j = 0; j < 16; j++) begin
      tb[j] = 8'd0;
    end
    for (int j = 0; j < TailBytes; j++) begin
      tb[j] = snap_i.bytes[j];
    end
  end

  // Remaining visits; each advances by at least one byte, so five steps cover the window.
  always_comb begin
    act  = snap_i.pending;
    off  = 4'(snap_i.next_start - snap_i.pos + 17'd4);
    zero = snap_i.zero_seen;
    cls  = snap_i.intf_class;
    addr = snap_i.ep_addr;
    mps  = snap_i.ep_mps;
    len  = '0;
    kind = '0;
    for (int i = 0; i < TailBytes; i++) begin
      if (act && off <= 4'd4) begin
        if (past_end[off[2:0]]) begin
          act = 1'b0;
        end else begin
          len  = tb[off];
          kind = tb[off + 4'd1];
          if (kind == KindInterface) begin
            cls = tb[off + 4'd5];
          end else if (kind == KindEndpoint && tb[off + 4'd3][1:0] == InterruptAttr) begin
            addr = tb[off + 4'd2];
            mps  = {tb[off + 4'd5], tb[off + 4'd4]};
          end
          if (len == 8'd0) begin
            zero = 1'b1;
            act  = 1'b0;
          end else if (len > 8'd4) begin
            act = 1'b0;
          end else begin
            off = off + len[3:0];
          end
        end
      end
    end

    // Status and result fields.
    id_d  = '0;
    mps_d = '0;
    if (!snap_i.header_ok) begin
      status_d = StatusNotConfig;
    end else if (zero) begin
      status_d = StatusZeroLength;
    end else if (cls != HubClass || addr == 8'd0) begin
      status_d = StatusNoHub;
    end else begin
      status_d = StatusHubFound;
      id_d     = {addr[3:0], addr[7]};
      mps_d    = (mps == 16'd0) ? DefaultMps : mps;
    end
  end

  // Result register occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (snap_take_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (snap_take_o) begin
      status_q <= status_d;
      id_q     <= id_d;
      mps_q    <= mps_d;
    end
  end

endmodule

[rtl/uhcdp_checker.sv]
// Port-level assertions for the descriptor parser and their binding to the top level.
module uhcdp_checker import uhcdp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        last_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [4:0]  endpoint_id_o,
  input logic [15:0] max_packet_o
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(endpoint_id_o) && $stable(max_packet_o))
    else $error("stalled result changed");

  // Any failure status carries zero fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StatusHubFound |-> endpoint_id_o == 5'd0 &&
      max_packet_o == 16'd0)
    else $error("failure status with nonzero fields");

  // A found hub never reports a zero max packet size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StatusHubFound |-> max_packet_o != 16'd0)
    else $error("hub result with zero max packet size");

  // With the result register empty the parser always takes input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // A last byte taken with no result held, then out_ready_i, yields a valid result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_byte_i && !out_valid_o) ##1 out_ready_i
      |=> out_valid_o)
    else $error("result missing after last byte transfer");

endmodule

bind usb_hub_config_descriptor_parser uhcdp_checker u_uhcdp_checker (.*);

[tb/sv/usb_hub_config_descriptor_parser_test.sv]
// Self-checking testbench for the hub configuration descriptor parser.
module usb_hub_config_descriptor_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import uhcdp_pkg::*;

  localparam int ItemTarget  = 1750;
  localparam int TailQuiet   = 250;
  localparam int HoldAfter   = 600;
  localparam int HoldCycles  = 300;
  localparam int StallLimit  = 3000;
  localparam int DrainCycles = 10;
  localparam int ReportLimit = 10;

  // One descriptor byte as offered on the input channel.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } desc_byte_t;

  // One parse report as produced on the output channel.
  typedef struct packed {
    status_e     status;
    logic [4:0]  ep_id;
    logic [15:0] mps;
  } hub_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [4:0]  endpoint_id_o;
  logic [15:0] max_packet_o;

  usb_hub_config_descriptor_parser u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .endpoint_id_o(endpoint_id_o),
    .max_packet_o (max_packet_o)
  );

  desc_byte_t  pending_bytes[$];
  hub_report_t expected_reports[$];
  logic [7:0]  desc_buf[$];
  int          mismatch_count = 0;
  int          bytes_taken = 0;
  int          idle_cycles = 0;
  logic        byte_taken = 1'b0;

  // Shadow state of the descriptor walk.
  int unsigned walk_pos;
  logic [15:0] walk_total;
  int unsigned walk_next;
  logic        walk_hdr_ok;
  logic        walk_done;
  logic        walk_zero_seen;
  logic [7:0]  walk_class;
  logic [7:0]  walk_ep_addr;
  logic [15:0] walk_ep_mps;
  logic [7:0]  walk_win[8];

  function automatic void walk_reset();
    walk_pos       = 0;
    walk_total     = '0;
    walk_next      = FirstSubStart;
    walk_hdr_ok    = 1'b0;
    walk_done      = 1'b0;
    walk_zero_seen = 1'b0;
    walk_class     = '0;
    walk_ep_addr   = '0;
    walk_ep_mps    = '0;
    foreach (walk_win[i]) walk_win[i] = '0;
  endfunction

  // Bytes not yet received read as zero.
  function automatic logic [7:0] win_byte(int unsigned q, int unsigned p);
    if (q > p) return 8'h00;
    return walk_win[q % 8];
  endfunction

  // Evaluate the sub-descriptor that starts at the current walk offset.
  function automatic void visit_sub(int unsigned p);
    int unsigned s;
    logic [7:0] len;
    logic [7:0] kind;
    logic [7:0] attr;
    s = walk_next;
    if (s + 2 >= walk_total || s > p) begin
      walk_done = 1'b1;
      return;
    end
    len  = win_byte(s, p);
    kind = win_byte(s + 1, p);
    attr = win_byte(s + 3, p);
    if (kind == KindInterface) begin
      walk_class = win_byte(s + 5, p);
    end else if (kind == KindEndpoint && attr[1:0] == InterruptAttr) begin
      walk_ep_addr = win_byte(s + 2, p);
      walk_ep_mps  = {win_byte(s + 5, p), win_byte(s + 4, p)};
    end
    if (len == 8'h00) begin
      walk_zero_seen = 1'b1;
      walk_done      = 1'b1;
    end else begin
      walk_next = s + len;
    end
  endfunction

  // Feed one accepted byte to the shadow walk; returns 1 with a report on the last byte.
  function automatic bit absorb_byte(logic [7:0] d, logic last, output hub_report_t rep);
    int unsigned p;
    int k;
    p   = walk_pos;
    rep = '0;
    walk_win[p % 8] = d;
    if (p == 1) walk_hdr_ok = (d == ConfigType);
    else if (p == 2) walk_total[7:0] = d;
    else if (p == 3) walk_total[15:8] = d;
    if (!walk_done && walk_next + TailBytes == p) visit_sub(p);
    if (!last) begin
      if (walk_pos < PosMax) walk_pos++;
      return 1'b0;
    end
    // Finish the sub-descriptors that start at or before the last byte.
    for (k = 0; k < 8; k++) begin
      if (walk_done || walk_next > p) break;
      visit_sub(p);
    end
    if (!walk_hdr_ok) begin
      rep.status = StatusNotConfig;
    end else if (walk_zero_seen) begin
      rep.status = StatusZeroLength;
    end else if (walk_class != HubClass || walk_ep_addr == 8'h00) begin
      rep.status = StatusNoHub;
    end else begin
      rep.status = StatusHubFound;
      rep.ep_id  = {walk_ep_addr[3:0], walk_ep_addr[7]};
      rep.mps    = (walk_ep_mps != 16'h0000) ? walk_ep_mps : DefaultMps;
    end
    walk_reset();
    return 1'b1;
  endfunction

  function automatic void note_miss(string msg);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) $display("mismatch: %s", msg);
  endfunction

  // Move the assembled descriptor into the input queue, marking its final byte.
  task automatic emit_desc();
    desc_byte_t item;
    foreach (desc_buf[i]) begin
      item.data = desc_buf[i];
      item.last = (i == desc_buf.size() - 1);
      pending_bytes.push_back(item);
    end
    desc_buf = {};
  endtask

  // Append one random sub-descriptor: interface, endpoint, other, short or zero-length.
  task automatic add_sub();
    int pick;
    int len;
    logic [7:0] attr;
    pick = $urandom_range(0, 19);
    if (pick < 7) begin
      desc_buf.push_back(8'd9);
      desc_buf.push_back(KindInterface);
      repeat (3) desc_buf.push_back(8'($urandom));
      desc_buf.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : HubClass);
      repeat (3) desc_buf.push_back(8'($urandom));
    end else if (pick < 14) begin
      attr = 8'($urandom);
      if ($urandom_range(0, 3) != 0) attr[1:0] = InterruptAttr;
      desc_buf.push_back(8'd7);
      desc_buf.push_back(KindEndpoint);
      desc_buf.push_back(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom));
      desc_buf.push_back(attr);
      case ($urandom_range(0, 5))
        0: begin
          desc_buf.push_back(8'h00);
          desc_buf.push_back(8'h00);
        end
        1: begin
          desc_buf.push_back(8'hFF);
          desc_buf.push_back(8'hFF);
        end
        default: begin
          desc_buf.push_back(8'($urandom));
          desc_buf.push_back(8'($urandom));
        end
      endcase
      desc_buf.push_back(8'($urandom));
    end else if (pick < 17) begin
      len = $urandom_range(3, 12);
      desc_buf.push_back(8'(len));
      repeat (len - 1) desc_buf.push_back(8'($urandom));
    end else if (pick < 19) begin
      // Short lengths make the fields overlap the next descriptor.
      len = $urandom_range(1, 5);
      desc_buf.push_back(8'(len));
      if (len >= 2) desc_buf.push_back($urandom_range(0, 1) ? KindInterface : KindEndpoint);
      repeat (len - 2) desc_buf.push_back(8'($urandom));
    end else begin
      desc_buf.push_back(8'h00);
      repeat ($urandom_range(0, 4)) desc_buf.push_back(8'($urandom));
    end
  endtask

  // A configuration descriptor with random content; some have a wrong type, a bad length, or are cut short or padded.
  task automatic build_config();
    int total;
    int cut;
    desc_buf = {};
    desc_buf.push_back(8'd9);
    desc_buf.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : ConfigType);
    desc_buf.push_back(8'h00);
    desc_buf.push_back(8'h00);
    repeat (5) desc_buf.push_back(8'($urandom));
    repeat ($urandom_range(0, 4)) add_sub();
    case ($urandom_range(0, 9))
      0: total = $urandom_range(0, desc_buf.size() + 16);
      1: total = $urandom_range(0, 16'hFFFF);
      default: total = desc_buf.size();
    endcase
    desc_buf[2] = total[7:0];
    desc_buf[3] = total[15:8];
    case ($urandom_range(0, 9))
      0: begin
        cut = $urandom_range(1, desc_buf.size());
        while (desc_buf.size() > cut) void'(desc_buf.pop_back());
      end
      1: repeat ($urandom_range(1, 12)) desc_buf.push_back(8'($urandom));
      default: ;
    endcase
    emit_desc();
  endtask

  // Random bytes, sometimes with a valid type byte.
  task automatic build_noise();
    repeat ($urandom_range(1, 16)) desc_buf.push_back(8'($urandom));
    if (desc_buf.size() > 1 && $urandom_range(0, 3) == 0) desc_buf[1] = ConfigType;
    emit_desc();
  endtask

  task automatic build_stimulus();
    // Single byte: the type byte is missing.
    desc_buf = {8'hFF};
    emit_desc();
    // Good type but no length bytes.
    desc_buf = {8'h00, ConfigType};
    emit_desc();
    // Zero-length sub-descriptor right after the header.
    desc_buf = {8'd9, ConfigType, 8'd12, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    emit_desc();
    // Hub with an IN interrupt endpoint 15 and a zero max packet size.
    desc_buf = {8'd9, ConfigType, 8'd25, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'd50,
                8'd9, KindInterface, 8'h00, 8'h00, 8'h01, HubClass, 8'h00, 8'h00, 8'h00,
                8'd7, KindEndpoint, 8'h8F, 8'h03, 8'h00, 8'h00, 8'hFF};
    emit_desc();
    while (pending_bytes.size() < ItemTarget) begin
      if ($urandom_range(0, 3) != 0) build_config();
      else build_noise();
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sender: a new byte goes out only when the line is idle or the last one was taken.
  desc_byte_t next_item;
  int         send_gap = 0;
  logic       send_idle_on = 1'b1;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || byte_taken) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap = send_gap - 1;
        end else if (pending_bytes.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (send_idle_on && pending_bytes.size() > TailQuiet &&
                     $urandom_range(0, 4) == 0) begin
          in_valid_i <= 1'b0;
          send_gap = $urandom_range(0, 2);
        end else begin
          next_item = pending_bytes.pop_front();
          in_valid_i  <= 1'b1;
          data_byte_i <= next_item.data;
          last_byte_i <= next_item.last;
        end
      end
      if ($urandom_range(0, 63) == 0) send_idle_on = !send_idle_on;
    end
  end

  // Receiver: short random stalls, plus one long hold-off to back up the pipeline.
  int   recv_gap = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic recv_idle_on = 1'b1;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && bytes_taken >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left = hold_left - 1;
      end else if (recv_gap > 0) begin
        out_ready_i <= 1'b0;
        recv_gap = recv_gap - 1;
      end else if (recv_idle_on && pending_bytes.size() > TailQuiet &&
                   $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        recv_gap = $urandom_range(0, 2);
      end else begin
        out_ready_i <= 1'b1;
      end
      if ($urandom_range(0, 47) == 0) recv_idle_on = !recv_idle_on;
    end
  end

  // Monitor: predict on each input transfer, check each output transfer.
  hub_report_t fresh_report;
  hub_report_t want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      byte_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        bytes_taken++;
        if (absorb_byte(data_byte_i, last_byte_i, fresh_report)) begin
          expected_reports.push_back(fresh_report);
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          note_miss($sformatf("unexpected result: status %0d id %0d max packet %0d",
                              status_o, endpoint_id_o, max_packet_o));
        end else begin
          want = expected_reports.pop_front();
          if (status_o !== want.status) begin
            note_miss($sformatf("status: expected %0d, got %0d", want.status, status_o));
          end
          if (endpoint_id_o !== want.ep_id) begin
            note_miss($sformatf("endpoint id: expected %0d, got %0d",
                                want.ep_id, endpoint_id_o));
          end
          if (max_packet_o !== want.mps) begin
            note_miss($sformatf("max packet: expected %0d, got %0d",
                                want.mps, max_packet_o));
          end
        end
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    walk_reset();
    build_stimulus();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    #1 rst_ni = 1'b1;
    // Wait for every byte to be taken and every report to come out.
    while (pending_bytes.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
